[sv/ats_pkg.sv]
package ats_pkg;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned INDEX_W  = 10;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_TABLE = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
		logic [FRAC_W-1:0]   u_x;
		logic [FRAC_W-1:0]   u_y;
	} in_word_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               status;
	} out_word_t;
endpackage

[sv/ats_if.sv]
interface ats_in_if;
	import ats_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ats_out_if;
	import ats_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/ats_ram.sv]
module ats_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 16,
	parameter int unsigned AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/alias_table_sampler_unit.sv]
// Alias table sampler. Load words (cmd 0) write one 16-bit weight each, and the next
// word can follow at once unless the output is stalled; a load with last set starts a
// build of the alias table, during which no word is taken. The build runs a scale pass
// over the entries (read, then write), then small/large pairings (read, wait, write).
// A sample (cmd 1) goes through accept, table read, then the keep/alias compare.
// Samples with no built table (before the first build, or after loads not yet built)
// give status 1, index 0, the cycle after accept. Loads beyond capacity are dropped.
module alias_table_sampler_unit import ats_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = 1024
) (
	input logic   clk,
	input logic   arst_n,
	ats_in_if.sink    in_ch,
	ats_out_if.source out_ch
);
	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned TW = WEIGHT_W + CW;
	localparam int unsigned PW = TW + FRAC_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_WR, ST_PAIR_RD, ST_PAIR_WAIT, ST_PAIR_WR,
		ST_SAMP_WAIT, ST_SAMP_CMP
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [TW-1:0]      total_q;
	logic               ready_q;
	logic [CW-1:0]      i_q;
	logic [AW-1:0]      sh_q, st_q, lh_q, lt_q;
	logic [CW-1:0]      sl_q, ll_q;
	logic [AW-1:0]      sm_q, lg_q;
	logic               fwd_q;
	logic [FRAC_W-1:0]  uy_q;
	logic [AW-1:0]      col_q;
	logic               oval_q;
	out_word_t          opay_q;

	logic               w_we, t_we, a_we, s_we, l_we;
	logic [AW-1:0]      w_wa, t_wa, a_wa, s_wa, l_wa;
	logic [AW-1:0]      w_ra, t_ra, a_ra, s_ra, l_ra;
	logic [WEIGHT_W-1:0] w_wd, w_rd;
	logic [TW-1:0]      t_wd, t_rd;
	logic [AW-1:0]      a_wd, a_rd, s_wd, s_rd, l_wd, l_rd;
	logic [TW-1:0]      t_sm_q;

	logic [TW-1:0]      scaled;
	logic [TW-1:0]      pg;
	logic [FRAC_W+CW-1:0] colx;
	logic [PW-1:0]      lhs, rhs;
	logic               take;
	logic               set_out;
	in_word_t           p;

	assign p = in_ch.payload;
	assign take = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !(oval_q && !out_ch.ready);
	assign out_ch.valid = oval_q;
	assign out_ch.payload = opay_q;
	assign set_out = (state_q == ST_SAMP_CMP) ||
		(take && p.cmd == CMD_SAMPLE && (!ready_q || count_q == '0));

	assign scaled = TW'(w_rd) * TW'(count_q);
	assign pg = t_rd + t_sm_q - total_q;
	assign colx = (FRAC_W+CW)'(p.u_x) * (FRAC_W+CW)'(count_q);
	assign lhs = PW'(uy_q) * PW'(total_q);
	assign rhs = {t_rd, {FRAC_W{1'b0}}};

	ats_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(WEIGHT_W), .AW(AW)) u_w (
		.clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
	ats_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(TW), .AW(AW)) u_t (
		.clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	ats_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AW), .AW(AW)) u_a (
		.clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	ats_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AW), .AW(AW)) u_s (
		.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	ats_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AW), .AW(AW)) u_l (
		.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] x);
		logic [AW:0] y;
		y = {1'b0, x} + 1'b1;
		return (y >= (AW+1)'(MAX_ENTRIES)) ? '0 : y[AW-1:0];
	endfunction

	logic [CW-1:0] cnt_eff;
	assign cnt_eff = ready_q ? '0 : count_q;

	always_comb begin
		w_we = 1'b0; w_wa = cnt_eff[AW-1:0]; w_wd = p.weight; w_ra = i_q[AW-1:0];
		t_we = 1'b0; t_wa = i_q[AW-1:0]; t_wd = scaled; t_ra = col_q;
		a_we = 1'b0; a_wa = i_q[AW-1:0]; a_wd = i_q[AW-1:0]; a_ra = col_q;
		s_we = 1'b0; s_wa = st_q; s_wd = i_q[AW-1:0]; s_ra = sh_q;
		l_we = 1'b0; l_wa = lt_q; l_wd = i_q[AW-1:0]; l_ra = lh_q;
		case (state_q)
			ST_IDLE: begin
				w_we = take && p.cmd == CMD_LOAD && cnt_eff < CW'(MAX_ENTRIES);
				t_ra = colx[FRAC_W +: AW];
				a_ra = colx[FRAC_W +: AW];
			end
			ST_SCAN_WR: begin
				t_we = 1'b1; a_we = 1'b1;
				s_we = scaled < total_q;
				l_we = !(scaled < total_q);
			end
			ST_PAIR_WAIT: begin
				t_ra = l_rd;
			end
			ST_PAIR_WR: begin
				a_we = 1'b1; a_wa = sm_q; a_wd = lg_q;
				t_we = 1'b1; t_wa = lg_q; t_wd = pg;
				s_we = pg < total_q; s_wd = lg_q;
				l_we = !(pg < total_q); l_wd = lg_q;
			end
			ST_PAIR_RD: begin
				// small head just written into an empty list
				t_ra = fwd_q ? lg_q : s_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0; total_q <= '0; ready_q <= 1'b0;
			oval_q <= 1'b0; opay_q <= '0;
			i_q <= '0; sh_q <= '0; st_q <= '0; lh_q <= '0; lt_q <= '0;
			sl_q <= '0; ll_q <= '0;
			sm_q <= '0; lg_q <= '0; t_sm_q <= '0; fwd_q <= 1'b0;
			uy_q <= '0; col_q <= '0;
		end else begin
			if (set_out) oval_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) oval_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (p.cmd == CMD_LOAD) begin
							if (cnt_eff < CW'(MAX_ENTRIES)) begin
								count_q <= cnt_eff + 1'b1;
								total_q <= (ready_q ? '0 : total_q) + TW'(p.weight);
							end else begin
								count_q <= cnt_eff;
								if (ready_q) total_q <= '0;
							end
							ready_q <= 1'b0;
							if (p.last) begin
								i_q <= '0; sh_q <= '0; st_q <= '0; lh_q <= '0; lt_q <= '0;
								sl_q <= '0; ll_q <= '0; fwd_q <= 1'b0;
								state_q <= ST_SCAN_RD;
							end
						end else if (!ready_q || count_q == '0) begin
							opay_q <= '{index: '0, status: STATUS_NO_TABLE};
						end else begin
							col_q <= colx[FRAC_W +: AW];
							uy_q <= p.u_y;
							state_q <= ST_SAMP_WAIT;
						end
					end
				end
				ST_SAMP_WAIT: state_q <= ST_SAMP_CMP;
				ST_SAMP_CMP: begin
					opay_q <= '{index: (lhs <= rhs) ? INDEX_W'(col_q) : INDEX_W'(a_rd),
						status: STATUS_OK};
					state_q <= ST_IDLE;
				end
				ST_SCAN_RD: begin
					if (i_q >= count_q) begin
						state_q <= ST_PAIR_RD;
					end else begin
						state_q <= ST_SCAN_WR;
					end
				end
				ST_SCAN_WR: begin
					if (scaled < total_q) begin
						st_q <= wrap(st_q); sl_q <= sl_q + 1'b1;
					end else begin
						lt_q <= wrap(lt_q); ll_q <= ll_q + 1'b1;
					end
					i_q <= i_q + 1'b1;
					state_q <= ST_SCAN_RD;
				end
				ST_PAIR_RD: begin
					if (sl_q == '0 || ll_q == '0) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PAIR_WAIT;
					end
				end
				ST_PAIR_WAIT: begin
					sm_q <= s_rd; lg_q <= l_rd; t_sm_q <= t_rd;
					sh_q <= wrap(sh_q); lh_q <= wrap(lh_q);
					sl_q <= sl_q - 1'b1; ll_q <= ll_q - 1'b1;
					state_q <= ST_PAIR_WR;
				end
				ST_PAIR_WR: begin
					if (pg < total_q) begin
						st_q <= wrap(st_q); sl_q <= sl_q + 1'b1;
					end else begin
						lt_q <= wrap(lt_q); ll_q <= ll_q + 1'b1;
					end
					fwd_q <= (pg < total_q) && (sl_q == '0);
					state_q <= ST_PAIR_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[verif/alias_table_sampler_unit_test.sv]
module alias_table_sampler_unit_test;
	import ats_pkg::*;

	localparam int unsigned ENTRIES = 1024;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		in_word_t  w;
		bit        fixed;
		out_word_t r;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ats_in_if  in_ch ();
	ats_out_if out_ch ();

	alias_table_sampler_unit #(.MAX_ENTRIES(ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the table
	logic [WEIGHT_W-1:0] p_weight [ENTRIES];
	logic [INDEX_W-1:0]  p_alias [ENTRIES];
	longint unsigned     p_thresh [ENTRIES];
	int unsigned         p_count;
	longint unsigned     p_total;
	bit                  p_ready;

	out_word_t expected_q[$];
	stim_row_t directed[$];
	int   mismatches = 0;
	bit   failed = 0;
	int   send_idle = 14;
	int   recv_idle = 54;
	longint cycles = 0;

	function automatic void build_alias_table();
		int unsigned small_q[$];
		int unsigned large_q[$];
		int unsigned sm;
		int unsigned lg;
		longint unsigned pg;
		for (int unsigned i = 0; i < p_count; i++) begin
			p_thresh[i] = longint'(p_weight[i]) * p_count;
			p_alias[i] = i[INDEX_W-1:0];
			if (p_thresh[i] >= p_total) large_q.insert(large_q.size(), i);
			else small_q.insert(small_q.size(), i);
		end
		while (small_q.size() > 0 && large_q.size() > 0) begin
			sm = small_q.pop_front();
			lg = large_q.pop_front();
			p_alias[sm] = lg[INDEX_W-1:0];
			pg = p_thresh[lg] + p_thresh[sm] - p_total;
			p_thresh[lg] = pg;
			if (pg < p_total) small_q.insert(small_q.size(), lg);
			else large_q.insert(large_q.size(), lg);
		end
		p_ready = 1;
	endfunction

	function automatic bit predict_draw(input in_word_t w, output out_word_t r);
		int unsigned col;
		r = '0;
		if (w.cmd == CMD_LOAD) begin
			if (p_ready) begin
				p_count = 0;
				p_total = 0;
				p_ready = 0;
			end
			if (p_count < ENTRIES) begin
				p_weight[p_count] = w.weight;
				p_count++;
				p_total += w.weight;
			end
			if (w.last) build_alias_table();
			return 0;
		end
		if (!p_ready || p_count == 0) begin
			r.index = '0;
			r.status = STATUS_NO_TABLE;
			return 1;
		end
		col = 32'((longint'(w.u_x) * p_count) >> 16);
		if (col >= p_count) col = 0;
		r.status = STATUS_OK;
		if (longint'(w.u_y) * p_total <= (p_thresh[col] << 16)) r.index = col[INDEX_W-1:0];
		else r.index = p_alias[col];
		return 1;
	endfunction

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word index=%0d status=%0d",
						out_ch.payload.index, out_ch.payload.status);
			end else begin
				out_word_t e;
				e = expected_q.pop_front();
				if (e.index !== out_ch.payload.index || e.status !== out_ch.payload.status) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp index=%0d status=%0d got index=%0d status=%0d",
							e.index, e.status, out_ch.payload.index, out_ch.payload.status);
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic drive_word(input in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= in_word_t'({$urandom, $urandom});
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic hold_off();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		in_ch.payload <= in_word_t'({$urandom, $urandom});
	endtask

	task automatic send_word(input in_word_t w);
		out_word_t r;
		drive_word(w);
		if (predict_draw(w, r)) expected_q.insert(expected_q.size(), r);
	endtask

	function automatic in_word_t mk(input logic c, input logic [15:0] wt, input logic l,
			input logic [15:0] ux, input logic [15:0] uy);
		in_word_t w;
		w.cmd = c; w.weight = wt; w.last = l; w.u_x = ux; w.u_y = uy;
		return w;
	endfunction

	function automatic void add_row(input in_word_t w, input bit fixed, input out_word_t r);
		stim_row_t row;
		row.w = w;
		row.fixed = fixed;
		row.r = r;
		directed.insert(directed.size(), row);
	endfunction

	function automatic in_word_t rand_sample();
		int unsigned k;
		logic [15:0] ux;
		logic [15:0] uy;
		k = $urandom_range(7);
		ux = (k == 0) ? 16'hffff : ((k == 1) ? 16'h0 : 16'($urandom));
		uy = (k == 2) ? 16'hffff : ((k == 3) ? 16'h0 : 16'($urandom));
		return mk(CMD_SAMPLE, 16'($urandom), 1'($urandom), ux, uy);
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(5))
			0: return 16'h0;
			1: return 16'hffff;
			2: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int n;
		int phase;
		int drawn;
		out_word_t r;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		add_row(mk(CMD_SAMPLE, 16'hffff, 1'b1, 16'hffff, 16'hffff), 1'b1,
			'{index: '0, status: STATUS_NO_TABLE});
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'h0, 16'h0), 1'b1,
			'{index: '0, status: STATUS_NO_TABLE});
		add_row(mk(CMD_LOAD, 16'h0, 1'b0, 16'hffff, 16'hffff), 1'b0, '0);
		add_row(mk(CMD_LOAD, 16'h0, 1'b1, 16'h0, 16'h0), 1'b0, '0);
		// all weights zero: column kept
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'hffff, 16'hffff), 1'b1,
			'{index: 10'd1, status: STATUS_OK});
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'h0, 16'h0), 1'b1,
			'{index: '0, status: STATUS_OK});
		// load after build restarts the table
		add_row(mk(CMD_LOAD, 16'hffff, 1'b0, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(CMD_LOAD, 16'h0, 1'b0, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(CMD_LOAD, 16'h1, 1'b0, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(CMD_LOAD, 16'h8000, 1'b1, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'hffff, 16'hffff), 1'b0, '0);
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'h4000, 16'hffff), 1'b0, '0);
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'h8000, 16'h0), 1'b0, '0);
		add_row(mk(CMD_SAMPLE, 16'hffff, 1'b1, 16'h0, 16'h7fff), 1'b0, '0);
		add_row(mk(CMD_LOAD, 16'h1234, 1'b1, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(CMD_SAMPLE, 16'h0, 1'b0, 16'hffff, 16'hffff), 1'b1,
			'{index: '0, status: STATUS_OK});
		foreach (directed[i]) begin
			if (directed[i].fixed) begin
				// keep predictor state in step without queuing twice
				void'(predict_draw(directed[i].w, r));
				expected_q.insert(expected_q.size(), directed[i].r);
				drive_word(directed[i].w);
			end else begin
				send_word(directed[i].w);
			end
		end

		// capacity: fill past the top, last on a dropped load
		for (int i = 0; i < ENTRIES + 3; i++)
			send_word(mk(CMD_LOAD, rand_weight(), i == ENTRIES + 2, 16'($urandom),
				16'($urandom)));
		repeat (20) send_word(rand_sample());

		drawn = 0;
		for (phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 14 : (phase == 1 ? 54 : 0);
			recv_idle = phase == 0 ? 54 : (phase == 1 ? 14 : 0);
			while (drawn < 150 * (phase + 1)) begin
				case ($urandom_range(9))
					0: begin
						// noise: random word of any kind
						in_word_t w;
						w = in_word_t'({$urandom, $urandom});
						send_word(w);
						drawn++;
					end
					1, 2: begin
						n = ($urandom_range(9) == 0) ? int'($urandom_range(40, 200)) :
							int'($urandom_range(1, 8));
						for (int i = 0; i < n; i++)
							send_word(mk(CMD_LOAD, rand_weight(), i == n - 1,
								16'($urandom), 16'($urandom)));
						drawn += n;
					end
					default: begin
						n = int'($urandom_range(1, 20));
						repeat (n) send_word(rand_sample());
						drawn += n;
					end
				endcase
			end
			if (phase == 0) begin
				// hold off until the pipeline drains
				hold_off();
				while (expected_q.size() > 0) @(posedge clk);
			end
		end

		hold_off();
		while (expected_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed && expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
